/* sv/graph_bfs_dfs_traversal_core_macros.svh */
// ----------------------------------------------------------------------------
// Graph traversal core assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef GRAPH_BFS_DFS_TRAVERSAL_CORE_MACROS_SVH
`define GRAPH_BFS_DFS_TRAVERSAL_CORE_MACROS_SVH

// same-cycle implication
`define GBT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("graph traversal core check failed");

// next-cycle implication
`define GBT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("graph traversal core check failed");

`endif

/* sv/gbt_pkg.sv */
// ----------------------------------------------------------------------------
// gbt_pkg
// Shared constants, codes and state type of the graph traversal core.
// ----------------------------------------------------------------------------
`default_nettype none

package gbt_pkg;

  localparam int unsigned NODES_DEF      = 16;
  localparam int unsigned MAX_DEGREE_DEF = 16;

  localparam int unsigned NODE_W   = 4;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned NCNT_W   = 5;
  localparam int unsigned PADDR_W  = 2;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [PADDR_W-1:0] REG_NODE_COUNT = 2'd0;

  localparam logic [OP_W-1:0] OP_ADD_EDGE = 2'd0;
  localparam logic [OP_W-1:0] OP_BFS      = 2'd1;
  localparam logic [OP_W-1:0] OP_DFS      = 2'd2;
  localparam logic [OP_W-1:0] OP_NONE     = 2'd3;

  localparam logic [STATUS_W-1:0] ST_ADDED    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_VISITED  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd3;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_EDGE_A = 8'b0000_0010,
    S_EDGE_B = 8'b0000_0100,
    S_EDGE_W = 8'b0000_1000,
    S_POP    = 8'b0001_0000,
    S_CUR    = 8'b0010_0000,
    S_DEG    = 8'b0100_0000,
    S_SCAN   = 8'b1000_0000
  } gbt_state_e;

endpackage

`default_nettype wire

/* sv/gbt_adj.sv */
// ----------------------------------------------------------------------------
// gbt_adj
// Adjacency storage: neighbor list memory and per-node degree memory.
// ----------------------------------------------------------------------------
`default_nettype none

module gbt_adj #(
  parameter int unsigned NODES      = gbt_pkg::NODES_DEF,
  parameter int unsigned MAX_DEGREE = gbt_pkg::MAX_DEGREE_DEF,
  localparam int unsigned IW = $clog2(NODES),
  localparam int unsigned DW = $clog2(MAX_DEGREE + 1),
  localparam int unsigned AW = $clog2(NODES * MAX_DEGREE)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // degree memory
  input  wire logic [IW-1:0] deg_ra_i,
  output      logic [DW-1:0] deg_rd_o,
  input  wire logic          deg_we_i,
  input  wire logic [IW-1:0] deg_wa_i,
  input  wire logic [DW-1:0] deg_wd_i,
  // neighbor memory
  input  wire logic [AW-1:0] nbr_ra_i,
  output      logic [IW-1:0] nbr_rd_o,
  input  wire logic          nbr_we_i,
  input  wire logic [AW-1:0] nbr_wa_i,
  input  wire logic [IW-1:0] nbr_wd_i
);

  localparam int unsigned NBR_DEPTH = NODES * MAX_DEGREE;

  logic [DW-1:0]    deg_mem [NODES];
  logic [NODES-1:0] deg_vld_q;
  logic [DW-1:0]    deg_raw_q;
  logic             deg_rvld_q;
  logic [IW-1:0]    nbr_mem [NBR_DEPTH];
  logic [IW-1:0]    nbr_rd_q;

  // degree lists start empty: an entry not yet written reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deg_vld_q  <= '0;
      deg_rvld_q <= 1'b0;
    end else begin
      deg_rvld_q <= deg_vld_q[deg_ra_i];
      if (deg_we_i) begin
        deg_vld_q[deg_wa_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    deg_raw_q <= deg_mem[deg_ra_i];
    if (deg_we_i) begin
      deg_mem[deg_wa_i] <= deg_wd_i;
    end
  end

  assign deg_rd_o = deg_rvld_q ? deg_raw_q : '0;

  always_ff @(posedge clk_i) begin
    nbr_rd_q <= nbr_mem[nbr_ra_i];
    if (nbr_we_i) begin
      nbr_mem[nbr_wa_i] <= nbr_wd_i;
    end
  end

  assign nbr_rd_o = nbr_rd_q;

endmodule

`default_nettype wire

/* sv/gbt_pend.sv */
// ----------------------------------------------------------------------------
// gbt_pend
// Pending node store, used as FIFO or LIFO by the sequencer's pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module gbt_pend #(
  parameter int unsigned NODES = gbt_pkg::NODES_DEF,
  localparam int unsigned IW = $clog2(NODES)
) (
  input  wire logic          clk_i,
  input  wire logic [IW-1:0] ra_i,
  output      logic [IW-1:0] rd_o,
  input  wire logic          we_i,
  input  wire logic [IW-1:0] wa_i,
  input  wire logic [IW-1:0] wd_i
);

  logic [IW-1:0] mem [NODES];
  logic [IW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    rd_q <= mem[ra_i];
    if (we_i) begin
      mem[wa_i] <= wd_i;
    end
  end

  assign rd_o = rd_q;

endmodule

`default_nettype wire

/* sv/graph_bfs_dfs_traversal_core.sv */
// ----------------------------------------------------------------------------
// graph_bfs_dfs_traversal_core
// Undirected graph store with breadth-first and depth-first traversal.
// ----------------------------------------------------------------------------
// Usage:
//   Config: APB register node_count at byte address 0 (write only while idle).
//   Items:  an item is taken when start is high and busy is low. op selects
//           add edge, breadth-first or depth-first traversal.
//   Results: one cycle on node_o/status_o/last_o with result_strobe_o high;
//           last_o marks the final result of the item. No back-pressure.
// Sequence:
//   Endpoint out of range, invalid start: result in the cycle after the item
//   is taken. Full list: two degree reads, then the reject.
//   Added edge: two degree reads, two list writes.
//   Traversal: each visited node is popped and its degree read, then each
//   of its stored neighbor entries is read; every neighbor list entry goes
//   through the one shared address unit and the single neighbor read port.
//   A visit result comes out once the next pop (or the end) is known.
//   op 3 is dropped and the block stays idle.
// Reset: degree lists empty (per-node valid bits), node_count = NODES,
//   no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_bfs_dfs_traversal_core #(
  parameter int unsigned NODES      = gbt_pkg::NODES_DEF,
  parameter int unsigned MAX_DEGREE = gbt_pkg::MAX_DEGREE_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [gbt_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [gbt_pkg::PDATA_W-1:0]   pwdata,
  output      logic [gbt_pkg::PDATA_W-1:0]   prdata,
  output      logic                          pready,
  // items
  input  wire logic                          start,
  output      logic                          busy,
  input  wire logic [gbt_pkg::OP_W-1:0]      op_i,
  input  wire logic [gbt_pkg::NODE_W-1:0]    node_a_i,
  input  wire logic [gbt_pkg::NODE_W-1:0]    node_b_i,
  // results
  output      logic                          result_strobe_o,
  output      logic [gbt_pkg::NODE_W-1:0]    node_o,
  output      logic [gbt_pkg::STATUS_W-1:0]  status_o,
  output      logic                          last_o
);

  localparam int unsigned IW    = $clog2(NODES);
  localparam int unsigned CW    = $clog2(NODES + 1);
  localparam int unsigned DW    = $clog2(MAX_DEGREE + 1);
  localparam int unsigned AW    = $clog2(NODES * MAX_DEGREE);
  localparam int unsigned LIM_W = (CW > gbt_pkg::NCNT_W) ? CW : gbt_pkg::NCNT_W;
  localparam int unsigned CMP_W = (CW > gbt_pkg::NODE_W) ? CW : gbt_pkg::NODE_W;

  // ---------------- configuration register ----------------
  logic [gbt_pkg::NCNT_W-1:0] node_count_q;
  logic                       cfg_wr;

  assign cfg_wr = psel && penable && pwrite && pready && (paddr == gbt_pkg::REG_NODE_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= gbt_pkg::NCNT_W'(NODES);
    end else if (cfg_wr) begin
      node_count_q <= pwdata[gbt_pkg::NCNT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == gbt_pkg::REG_NODE_COUNT) ?
                  gbt_pkg::PDATA_W'(node_count_q) : '0;

  // active node count, clipped at NODES
  logic [LIM_W-1:0] ncnt_ext;
  logic [CW-1:0]    n_act;

  assign ncnt_ext = LIM_W'(node_count_q);
  assign n_act    = (ncnt_ext > LIM_W'(NODES)) ? CW'(NODES) : CW'(ncnt_ext);

  // ---------------- sequencer state ----------------
  gbt_pkg::gbt_state_e state_q, state_d;
  logic [IW-1:0]    a_q, a_d, b_q, b_d, cur_q, cur_d;
  logic [DW-1:0]    deg_a_q, deg_a_d, deg_b_q, deg_b_d, deg_cur_q, deg_cur_d, k_q, k_d;
  logic [CW-1:0]    head_q, head_d, tail_q, tail_d;
  logic [NODES-1:0] visited_q, visited_d;
  logic             lifo_q, lifo_d, prev_vld_q, prev_vld_d;
  logic             scan_vld_q, scan_vld_d;

  logic                         res_strobe_q, res_strobe_d;
  logic [gbt_pkg::NODE_W-1:0]   res_node_q, res_node_d;
  logic [gbt_pkg::STATUS_W-1:0] res_status_q, res_status_d;
  logic                         res_last_q, res_last_d;

  // memory ports
  logic [IW-1:0] deg_ra, deg_wa, pend_ra, pend_wa, pend_wd, pend_rd, nbr_rd, nbr_wd;
  logic [DW-1:0] deg_rd, deg_wd;
  logic          deg_we, nbr_we, pend_we;
  logic [AW-1:0] list_addr;

  // shared address unit: node * MAX_DEGREE + entry index
  logic [IW-1:0] au_node;
  logic [DW-1:0] au_idx;

  assign list_addr = AW'(AW'(au_node) * AW'(MAX_DEGREE)) + AW'(au_idx);

  logic          accept, a_ok, b_ok, same, edge_ok, nb_new;
  logic [IW-1:0] in_a, in_b;
  logic [CW-1:0] tail_m1;
  logic [DW:0]   deg_a_p2;

  assign accept   = start && !busy;
  assign in_a     = IW'(node_a_i);
  assign in_b     = IW'(node_b_i);
  assign a_ok     = CMP_W'(node_a_i) < CMP_W'(n_act);
  assign b_ok     = CMP_W'(node_b_i) < CMP_W'(n_act);
  assign same     = (a_q == b_q);
  assign deg_a_p2 = {1'b0, deg_a_q} + (DW+1)'(2);
  assign edge_ok  = same ? (deg_a_p2 <= (DW+1)'(MAX_DEGREE))
                         : ((deg_a_q < DW'(MAX_DEGREE)) && (deg_rd < DW'(MAX_DEGREE)));
  assign tail_m1  = tail_q - CW'(1);
  // stale entries (beyond the active count) are skipped
  assign nb_new   = (CW'(nbr_rd) < n_act) && !visited_q[nbr_rd];

  assign busy = (state_q != gbt_pkg::S_IDLE);

  always_comb begin
    state_d      = state_q;
    a_d          = a_q;
    b_d          = b_q;
    cur_d        = cur_q;
    deg_a_d      = deg_a_q;
    deg_b_d      = deg_b_q;
    deg_cur_d    = deg_cur_q;
    k_d          = k_q;
    head_d       = head_q;
    tail_d       = tail_q;
    visited_d    = visited_q;
    lifo_d       = lifo_q;
    prev_vld_d   = prev_vld_q;
    res_strobe_d = 1'b0;
    res_node_d   = res_node_q;
    res_status_d = res_status_q;
    res_last_d   = res_last_q;
    deg_ra       = in_a;
    deg_we       = 1'b0;
    deg_wa       = a_q;
    deg_wd       = deg_a_q;
    nbr_we       = 1'b0;
    nbr_wd       = b_q;
    au_node      = cur_q;
    au_idx       = k_q;
    pend_ra      = head_q[IW-1:0];
    pend_we      = 1'b0;
    pend_wa      = tail_q[IW-1:0];
    pend_wd      = nbr_rd;

    unique case (state_q)
      gbt_pkg::S_IDLE: begin
        if (accept) begin
          a_d = in_a;
          b_d = in_b;
          unique case (op_i)
            gbt_pkg::OP_ADD_EDGE: begin
              if (a_ok && b_ok) begin
                state_d = gbt_pkg::S_EDGE_A;
              end else begin
                res_strobe_d = 1'b1;
                res_node_d   = '0;
                res_status_d = gbt_pkg::ST_REJECTED;
                res_last_d   = 1'b1;
              end
            end
            gbt_pkg::OP_BFS, gbt_pkg::OP_DFS: begin
              if (a_ok) begin
                lifo_d     = (op_i == gbt_pkg::OP_DFS);
                visited_d  = NODES'(1) << in_a;
                head_d     = '0;
                tail_d     = CW'(1);
                prev_vld_d = 1'b0;
                pend_we    = 1'b1;
                pend_wa    = '0;
                pend_wd    = in_a;
                state_d    = gbt_pkg::S_POP;
              end else begin
                res_strobe_d = 1'b1;
                res_node_d   = '0;
                res_status_d = gbt_pkg::ST_INVALID;
                res_last_d   = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end

      gbt_pkg::S_EDGE_A: begin
        deg_a_d = deg_rd;
        deg_ra  = b_q;
        state_d = gbt_pkg::S_EDGE_B;
      end

      gbt_pkg::S_EDGE_B: begin
        au_node = a_q;
        au_idx  = deg_a_q;
        if (edge_ok) begin
          nbr_we  = 1'b1;
          nbr_wd  = b_q;
          deg_we  = 1'b1;
          deg_wa  = a_q;
          deg_wd  = deg_a_q + DW'(1);
          // self loop: second entry goes right after the first
          deg_b_d = same ? (deg_a_q + DW'(1)) : deg_rd;
          state_d = gbt_pkg::S_EDGE_W;
        end else begin
          res_strobe_d = 1'b1;
          res_node_d   = '0;
          res_status_d = gbt_pkg::ST_REJECTED;
          res_last_d   = 1'b1;
          state_d      = gbt_pkg::S_IDLE;
        end
      end

      gbt_pkg::S_EDGE_W: begin
        au_node      = b_q;
        au_idx       = deg_b_q;
        nbr_we       = 1'b1;
        nbr_wd       = a_q;
        deg_we       = 1'b1;
        deg_wa       = b_q;
        deg_wd       = deg_b_q + DW'(1);
        res_strobe_d = 1'b1;
        res_node_d   = '0;
        res_status_d = gbt_pkg::ST_ADDED;
        res_last_d   = 1'b1;
        state_d      = gbt_pkg::S_IDLE;
      end

      gbt_pkg::S_POP: begin
        // previous visit goes out now that we know whether more follow
        res_node_d   = gbt_pkg::NODE_W'(cur_q);
        res_status_d = gbt_pkg::ST_VISITED;
        if (head_q < tail_q) begin
          res_strobe_d = prev_vld_q;
          res_last_d   = 1'b0;
          if (lifo_q) begin
            pend_ra = tail_m1[IW-1:0];
            tail_d  = tail_m1;
          end else begin
            pend_ra = head_q[IW-1:0];
            head_d  = head_q + CW'(1);
          end
          state_d = gbt_pkg::S_CUR;
        end else begin
          res_strobe_d = 1'b1;
          res_last_d   = 1'b1;
          state_d      = gbt_pkg::S_IDLE;
        end
      end

      gbt_pkg::S_CUR: begin
        cur_d      = pend_rd;
        deg_ra     = pend_rd;
        prev_vld_d = 1'b1;
        state_d    = gbt_pkg::S_DEG;
      end

      gbt_pkg::S_DEG: begin
        deg_cur_d = deg_rd;
        k_d       = '0;
        state_d   = gbt_pkg::S_SCAN;
      end

      gbt_pkg::S_SCAN: begin
        // one list read issued per cycle; the entry read last cycle is checked
        if (k_q < deg_cur_q) begin
          k_d = k_q + DW'(1);
        end else begin
          state_d = gbt_pkg::S_POP;
        end
        if (scan_vld_q && nb_new) begin
          visited_d[nbr_rd] = 1'b1;
          pend_we           = 1'b1;
          pend_wa           = tail_q[IW-1:0];
          pend_wd           = nbr_rd;
          tail_d            = tail_q + CW'(1);
        end
      end

      default: begin
        state_d = gbt_pkg::S_IDLE;
      end
    endcase
  end

  assign scan_vld_d = (state_q == gbt_pkg::S_SCAN) && (k_q < deg_cur_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= gbt_pkg::S_IDLE;
      res_strobe_q <= 1'b0;
      scan_vld_q   <= 1'b0;
      prev_vld_q   <= 1'b0;
      head_q       <= '0;
      tail_q       <= '0;
      visited_q    <= '0;
      lifo_q       <= 1'b0;
      k_q          <= '0;
    end else begin
      state_q      <= state_d;
      res_strobe_q <= res_strobe_d;
      scan_vld_q   <= scan_vld_d;
      prev_vld_q   <= prev_vld_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      visited_q    <= visited_d;
      lifo_q       <= lifo_d;
      k_q          <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q          <= a_d;
    b_q          <= b_d;
    cur_q        <= cur_d;
    deg_a_q      <= deg_a_d;
    deg_b_q      <= deg_b_d;
    deg_cur_q    <= deg_cur_d;
    res_node_q   <= res_node_d;
    res_status_q <= res_status_d;
    res_last_q   <= res_last_d;
  end

  assign result_strobe_o = res_strobe_q;
  assign node_o          = res_node_q;
  assign status_o        = res_status_q;
  assign last_o          = res_last_q;

  // ---------------- storage ----------------
  gbt_adj #(
    .NODES      (NODES),
    .MAX_DEGREE (MAX_DEGREE)
  ) u_adj (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .deg_ra_i (deg_ra),
    .deg_rd_o (deg_rd),
    .deg_we_i (deg_we),
    .deg_wa_i (deg_wa),
    .deg_wd_i (deg_wd),
    .nbr_ra_i (list_addr),
    .nbr_rd_o (nbr_rd),
    .nbr_we_i (nbr_we),
    .nbr_wa_i (list_addr),
    .nbr_wd_i (nbr_wd)
  );

  gbt_pend #(
    .NODES (NODES)
  ) u_pend (
    .clk_i (clk_i),
    .ra_i  (pend_ra),
    .rd_o  (pend_rd),
    .we_i  (pend_we),
    .wa_i  (pend_wa),
    .wd_i  (pend_wd)
  );

endmodule

`default_nettype wire

/* sv/gbt_checker.sv */
// ----------------------------------------------------------------------------
// gbt_checker
// Port-level checks of the graph traversal core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "graph_bfs_dfs_traversal_core_macros.svh"

module gbt_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         start,
  input wire logic                         busy,
  input wire logic [gbt_pkg::OP_W-1:0]     op_i,
  input wire logic                         result_strobe_o,
  input wire logic [gbt_pkg::NODE_W-1:0]   node_o,
  input wire logic [gbt_pkg::STATUS_W-1:0] status_o,
  input wire logic                         last_o,
  input wire logic                         pready
);

  // edge results are single and carry no node
  `GBT_ASSERT_IMP(a_edge_single, result_strobe_o && (status_o == gbt_pkg::ST_ADDED || status_o == gbt_pkg::ST_REJECTED), last_o && (node_o == '0))

  `GBT_ASSERT_IMP(a_invalid_single, result_strobe_o && (status_o == gbt_pkg::ST_INVALID), last_o && (node_o == '0))

  // unknown op is dropped without a trace
  `GBT_ASSERT_NXT(a_op_none_quiet, start && !busy && (op_i == gbt_pkg::OP_NONE), !result_strobe_o && !busy)

  // a real item either starts work or answers at once
  `GBT_ASSERT_NXT(a_item_reacts, start && !busy && (op_i == gbt_pkg::OP_ADD_EDGE || op_i == gbt_pkg::OP_BFS || op_i == gbt_pkg::OP_DFS), busy || result_strobe_o)

  `GBT_ASSERT_IMP(a_pready_high, 1'b1, pready)

endmodule

bind graph_bfs_dfs_traversal_core gbt_checker u_gbt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .op_i            (op_i),
  .result_strobe_o (result_strobe_o),
  .node_o          (node_o),
  .status_o        (status_o),
  .last_o          (last_o),
  .pready          (pready)
);

`default_nettype wire

/* bench/graph_bfs_dfs_traversal_core_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_bfs_dfs_traversal_core_checker
// Watches the register port, the item channel and the result strobe of the
// traversal core. Keeps its own copy of the graph, predicts the results of
// every accepted item and compares each strobed result, field by field.
// ----------------------------------------------------------------------------
module graph_bfs_dfs_traversal_core_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic                          pready_i,
  input  logic [gbt_pkg::PADDR_W-1:0]   paddr_i,
  input  logic [gbt_pkg::PDATA_W-1:0]   pwdata_i,
  input  logic [gbt_pkg::PDATA_W-1:0]   prdata_i,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  logic [gbt_pkg::OP_W-1:0]      op_i,
  input  logic [gbt_pkg::NODE_W-1:0]    node_a_i,
  input  logic [gbt_pkg::NODE_W-1:0]    node_b_i,
  input  logic                          res_strobe_i,
  input  logic [gbt_pkg::NODE_W-1:0]    res_node_i,
  input  logic [gbt_pkg::STATUS_W-1:0]  res_status_i,
  input  logic                          res_last_i,
  output int unsigned                   due_count_o,
  output int unsigned                   fault_count_o
);
  import gbt_pkg::*;

  localparam int unsigned NODES   = NODES_DEF;
  localparam int unsigned MAX_DEG = MAX_DEGREE_DEF;

  typedef struct packed {
    logic [NODE_W-1:0]   node;
    logic [STATUS_W-1:0] status;
    logic                last;
  } core_result_t;

  logic [NODE_W-1:0] adj [NODES][MAX_DEG];
  logic [NCNT_W-1:0] adj_len [NODES];
  logic [NCNT_W-1:0] live_nodes;
  core_result_t      due_results [$];
  int unsigned       faults = 0;

  assign fault_count_o = faults;

  task automatic report_mismatch(string what);
    $display("%0t ns  mismatch: %s", $time, what);
    faults++;
  endtask

  function automatic int unsigned active_limit();
    return (live_nodes > NODES) ? NODES : int'(live_nodes);
  endfunction

  function automatic void expect_result(logic [NODE_W-1:0] node, logic [STATUS_W-1:0] status,
                                        logic last);
    core_result_t r;
    r.node      = node;
    r.status    = status;
    r.last      = last;
    due_results = {due_results, r};
  endfunction

  function automatic void predict_edge(logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
    int unsigned lim;
    bit          ok;
    lim = active_limit();
    ok  = (a < lim) && (b < lim);
    if (ok) begin
      // a self loop takes two entries of the same list
      if (a == b) ok = (int'(adj_len[a]) + 2) <= MAX_DEG;
      else ok = (adj_len[a] < MAX_DEG) && (adj_len[b] < MAX_DEG);
    end
    if (ok) begin
      adj[a][adj_len[a]] = b;
      adj_len[a]         = adj_len[a] + 1'b1;
      adj[b][adj_len[b]] = a;
      adj_len[b]         = adj_len[b] + 1'b1;
    end
    expect_result('0, ok ? ST_ADDED : ST_REJECTED, 1'b1);
  endfunction

  function automatic void predict_walk(logic [NODE_W-1:0] root, bit lifo);
    int unsigned       lim, head, tail, visits, k;
    logic [NODES-1:0]  seen;
    logic [NODE_W-1:0] frontier [NODES];
    logic [NODE_W-1:0] cur, nb;
    lim = active_limit();
    if (root >= lim) begin
      expect_result('0, ST_INVALID, 1'b1);
      return;
    end
    seen           = '0;
    head           = 0;
    tail           = 0;
    visits         = 0;
    seen[root]     = 1'b1;
    frontier[tail] = root;
    tail++;
    while (head < tail && visits < NODES) begin
      if (lifo) begin
        tail--;
        cur = frontier[tail];
      end else begin
        cur = frontier[head];
        head++;
      end
      expect_result(cur, ST_VISITED, 1'b0);
      visits++;
      for (k = 0; k < adj_len[cur] && k < MAX_DEG; k++) begin
        nb = adj[cur][k];
        // neighbors left over from a larger node count are skipped
        if (nb < lim && !seen[nb] && tail < NODES) begin
          seen[nb]       = 1'b1;
          frontier[tail] = nb;
          tail++;
        end
      end
    end
    due_results[due_results.size() - 1].last = 1'b1;
  endfunction

  task automatic check_result();
    core_result_t want;
    if (due_results.size() == 0) begin
      report_mismatch($sformatf("result with nothing expected: node %0d status %0d last %0b",
                                res_node_i, res_status_i, res_last_i));
      return;
    end
    want = due_results.pop_front();
    if (res_node_i !== want.node)
      report_mismatch($sformatf("node %0d, expected %0d", res_node_i, want.node));
    if (res_status_i !== want.status)
      report_mismatch($sformatf("status %0d, expected %0d", res_status_i, want.status));
    if (res_last_i !== want.last)
      report_mismatch($sformatf("last %0b, expected %0b", res_last_i, want.last));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NODES; i++) adj_len[i] = '0;
      live_nodes = NCNT_W'(NODES);
      due_results.delete();
      due_count_o <= 0;
    end else begin
      // results first: a strobe on an accept edge belongs to an older item
      if (res_strobe_i) check_result();
      if (start_i && !busy_i) begin
        case (op_i)
          OP_ADD_EDGE: predict_edge(node_a_i, node_b_i);
          OP_BFS:      predict_walk(node_a_i, 1'b0);
          OP_DFS:      predict_walk(node_a_i, 1'b1);
          default: ;
        endcase
      end
      if (psel_i && penable_i && pready_i && paddr_i == REG_NODE_COUNT) begin
        if (pwrite_i) begin
          live_nodes = pwdata_i[NCNT_W-1:0];
        end else if (prdata_i !== PDATA_W'(live_nodes)) begin
          report_mismatch($sformatf("node_count read %0d, expected %0d", prdata_i, live_nodes));
        end
      end
      due_count_o <= due_results.size();
    end
  end

endmodule

/* bench/graph_bfs_dfs_traversal_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_bfs_dfs_traversal_core_tb
// Drives edge inserts and breadth/depth-first traversals into the core under
// a series of node counts, with bursty start timing; the checker predicts
// and compares every result and this module gives the verdict.
// ----------------------------------------------------------------------------
module graph_bfs_dfs_traversal_core_tb;
  import gbt_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400_000;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned DRAIN        = 64;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned RANDOM_ITEMS = 330;

  logic                 clk_i   = 1'b0;
  logic                 rst_ni  = 1'b0;
  logic                 psel    = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite  = 1'b0;
  logic [PADDR_W-1:0]   paddr   = '0;
  logic [PDATA_W-1:0]   pwdata  = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;
  logic                 start   = 1'b0;
  logic                 busy;
  logic [OP_W-1:0]      op_i     = '0;
  logic [NODE_W-1:0]    node_a_i = '0;
  logic [NODE_W-1:0]    node_b_i = '0;
  logic                 result_strobe_o;
  logic [NODE_W-1:0]    node_o;
  logic [STATUS_W-1:0]  status_o;
  logic                 last_o;

  int unsigned due_count, fault_count;
  int unsigned cycles     = 0;
  int unsigned burst_left = 0;
  int unsigned n_edge = 0, n_bfs = 0, n_dfs = 0, n_drop = 0, n_cfg = 0;

  graph_bfs_dfs_traversal_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .start           (start),
    .busy            (busy),
    .op_i            (op_i),
    .node_a_i        (node_a_i),
    .node_b_i        (node_b_i),
    .result_strobe_o (result_strobe_o),
    .node_o          (node_o),
    .status_o        (status_o),
    .last_o          (last_o)
  );

  graph_bfs_dfs_traversal_core_checker u_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .prdata_i      (prdata),
    .start_i       (start),
    .busy_i        (busy),
    .op_i          (op_i),
    .node_a_i      (node_a_i),
    .node_b_i      (node_b_i),
    .res_strobe_i  (result_strobe_o),
    .res_node_i    (node_o),
    .res_status_i  (status_o),
    .res_last_i    (last_o),
    .due_count_o   (due_count),
    .fault_count_o (fault_count)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("cycle limit reached with %0d results outstanding", due_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Offers one item; start stays high on return so a burst runs back to back.
  task automatic send_item(logic [OP_W-1:0] op, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap      = $urandom_range(12, 1);
      start    <= 1'b0;
      op_i     <= OP_W'($urandom);
      node_a_i <= NODE_W'($urandom);
      node_b_i <= NODE_W'($urandom);
      repeat (gap - 1) begin
        @(posedge clk_i);
        op_i     <= OP_W'($urandom);
        node_a_i <= NODE_W'($urandom);
        node_b_i <= NODE_W'($urandom);
      end
      @(posedge clk_i);
      burst_left = ($urandom_range(3) == 0) ? $urandom_range(40, 20) : $urandom_range(6, 1);
    end
    start    <= 1'b1;
    op_i     <= op;
    node_a_i <= a;
    node_b_i <= b;
    do @(posedge clk_i); while (busy);
    burst_left--;
    case (op)
      OP_ADD_EDGE: n_edge++;
      OP_BFS:      n_bfs++;
      OP_DFS:      n_dfs++;
      default:     n_drop++;
    endcase
  endtask

  task automatic wait_quiet();
    start <= 1'b0;
    do @(posedge clk_i); while (due_count != 0 || busy);
    // a dropped op gives no result, so let the block settle before going on
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // write node_count while idle, then read it back
  task automatic set_node_count(logic [NCNT_W-1:0] value);
    wait_quiet();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_NODE_COUNT;
    pwdata  <= {(PDATA_W-NCNT_W)'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    n_cfg++;
  endtask

  initial begin
    int unsigned       sent, lim, r;
    logic [NODE_W-1:0] a, b;
    logic [NCNT_W-1:0] counts [PHASES];
    counts    = '{5'd16, 5'd31, 5'd7, 5'd16, 5'd1, 5'd17, 5'd0, 5'd5, 5'd16, 5'd12};
    counts[7] = NCNT_W'($urandom_range(15, 2));

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: node_count at its reset value
    send_item(OP_ADD_EDGE, 4'd0, 4'd1);
    send_item(OP_ADD_EDGE, 4'd0, 4'd1);     // duplicate edge
    send_item(OP_ADD_EDGE, 4'd15, 4'd15);
    send_item(OP_ADD_EDGE, 4'd0, 4'd9);
    repeat (7) send_item(OP_ADD_EDGE, 4'd5, 4'd5);
    send_item(OP_ADD_EDGE, 4'd5, 4'd6);     // node 5 holds 15 entries
    send_item(OP_ADD_EDGE, 4'd5, 4'd5);     // self loop needs two, rejected
    send_item(OP_ADD_EDGE, 4'd5, 4'd15);
    send_item(OP_ADD_EDGE, 4'd5, 4'd0);     // list full
    send_item(OP_BFS, 4'd5, 4'd10);
    send_item(OP_DFS, 4'd0, 4'd15);
    send_item(OP_DFS, 4'd14, 4'd0);         // isolated start
    send_item(OP_NONE, 4'd15, 4'd15);
    set_node_count(5'd4);
    send_item(OP_ADD_EDGE, 4'd4, 4'd1);
    send_item(OP_ADD_EDGE, 4'd0, 4'd15);
    send_item(OP_BFS, 4'd5, 4'd0);
    send_item(OP_DFS, 4'd0, 4'd3);          // neighbor 9 is now stale
    send_item(OP_BFS, 4'd1, 4'd2);
    set_node_count(5'd0);
    send_item(OP_ADD_EDGE, 4'd0, 4'd0);
    send_item(OP_DFS, 4'd0, 4'd0);

    // random: mostly in-range graph building, mixed with traversals over it
    for (int p = 0; p < PHASES; p++) begin
      set_node_count(counts[p]);
      lim  = (counts[p] > NODES_DEF) ? NODES_DEF : counts[p];
      sent = 0;
      while (sent < RANDOM_ITEMS / PHASES) begin
        r = $urandom_range(99);
        a = NODE_W'($urandom);
        b = NODE_W'($urandom);
        if (r < 3) begin
          send_item(OP_NONE, a, b);
        end else begin
          if (lim > 0 && $urandom_range(9) < 8) begin
            a = NODE_W'($urandom_range(lim - 1));
            b = NODE_W'($urandom_range(lim - 1));
          end
          if (r < 62) begin
            if ($urandom_range(11) == 0) b = a;
            send_item(OP_ADD_EDGE, a, b);
          end else if (r < 81) begin
            send_item(OP_BFS, a, b);
          end else begin
            send_item(OP_DFS, a, b);
          end
          sent++;
        end
      end
    end

    wait_quiet();
    repeat (DRAIN) @(posedge clk_i);
    $display("covered %0d edge, %0d breadth-first, %0d depth-first, %0d dropped items",
             n_edge, n_bfs, n_dfs, n_drop);
    $display("across %0d node_count writes, %0d mismatches", n_cfg, fault_count);
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/gbt_pkg.sv
sv/gbt_adj.sv
sv/gbt_pend.sv
sv/graph_bfs_dfs_traversal_core.sv
sv/gbt_checker.sv
bench/graph_bfs_dfs_traversal_core_checker.sv
bench/graph_bfs_dfs_traversal_core_tb.sv
